### sv/pblre_pkg.sv
`default_nettype none

package pblre_pkg;

  // Length fields use their low LenBits bits
  localparam int unsigned LenBits    = 16;
  // Pair content size and record size increment
  localparam int unsigned CntBits    = LenBits + 2;
  localparam int unsigned AmtBits    = LenBits + 3;
  // Tag/varint segments a single descriptor may carry
  localparam int unsigned NumSegs    = 3;
  localparam int unsigned SegCntBits = 2;
  // Descriptor queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrBits   = 2;

  localparam logic [31:0] MinTime   = 32'd463563523;
  localparam logic [31:0] StartSize = 32'd6;

  localparam logic [7:0] TagTime   = 8'h08;
  localparam logic [7:0] TagPair   = 8'h12;
  localparam logic [7:0] TagKey    = 8'h0A;
  localparam logic [7:0] TagValue  = 8'h12;
  localparam logic [7:0] TagHeader = 8'h0A;

  typedef logic [LenBits-1:0] len_t;

  typedef enum logic [1:0] {
    OpStart = 2'd0,
    OpPair  = 2'd1,
    OpData  = 2'd2,
    OpDone  = 2'd3
  } op_e;

  // One tag byte followed by a varint
  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] val;
  } seg_t;

  // Byte burst for one accepted item: optional raw byte, then segments
  typedef struct packed {
    logic                  raw_en;
    logic [7:0]            raw_byte;
    logic                  err;
    logic                  hdr;
    logic                  tag_pend;
    logic [SegCntBits-1:0] nsegs;
    seg_t [NumSegs-1:0]    seg;
  } desc_t;

  // Number of bytes in the varint form of a value
  function automatic logic [2:0] varint_size(logic [31:0] v);
    logic [2:0] n;
    if (v[31:7] == '0) begin
      n = 3'd1;
    end else if (v[31:14] == '0) begin
      n = 3'd2;
    end else if (v[31:21] == '0) begin
      n = 3'd3;
    end else if (v[31:28] == '0) begin
      n = 3'd4;
    end else begin
      n = 3'd5;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### sv/pblre_front.sv
`default_nettype none

module pblre_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                [1:0]  op_i,
  input  wire logic                [31:0] log_time_i,
  input  wire logic                [15:0] key_length_i,
  input  wire logic                [15:0] value_length_i,
  input  wire logic                [7:0]  data_byte_i,
  input  wire logic                       full_i,
  output logic                            push_o,
  output pblre_pkg::desc_t                desc_o
);

  typedef enum logic [3:0] {
    PhIdle  = 4'b0001,
    PhOpen  = 4'b0010,
    PhKey   = 4'b0100,
    PhValue = 4'b1000
  } phase_e;

  phase_e                        phase_q, phase_d;
  pblre_pkg::len_t               left_q, left_d;
  pblre_pkg::len_t               vlen_q, vlen_d;
  logic [31:0]                   size_q, size_d;
  logic                          ovf_q, ovf_d;
  logic [pblre_pkg::AmtBits-1:0] amt_q, amt_d;

  logic [32:0]                   size_sum;
  logic [31:0]                   size_now;
  logic                          ovf_now;
  pblre_pkg::len_t               kl, vl, left_dec;
  logic [31:0]                   time_c;
  logic [pblre_pkg::CntBits-1:0] content;
  logic [pblre_pkg::AmtBits-1:0] amount;
  logic                          accept;

  // Take an item whenever the queue has room
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  // Lengths use their low LenBits bits
  assign kl       = pblre_pkg::len_t'(key_length_i);
  assign vl       = pblre_pkg::len_t'(value_length_i);
  assign left_dec = left_q - 1'b1;

  // Clamp the time up so its varint always takes five bytes
  assign time_c = (log_time_i < pblre_pkg::MinTime) ? pblre_pkg::MinTime : log_time_i;

  // Pair content size and the record size it adds
  assign content = pblre_pkg::CntBits'(kl) + pblre_pkg::CntBits'(vl)
                 + pblre_pkg::CntBits'(pblre_pkg::varint_size(32'(kl)))
                 + pblre_pkg::CntBits'(pblre_pkg::varint_size(32'(vl)))
                 + pblre_pkg::CntBits'(2);
  assign amount  = pblre_pkg::AmtBits'(content)
                 + pblre_pkg::AmtBits'(pblre_pkg::varint_size(32'(content)))
                 + pblre_pkg::AmtBits'(1);

  // Fold the last pair's size into the saturating record size
  assign size_sum = {1'b0, size_q} + 33'(amt_q);
  assign size_now = size_sum[32] ? '1 : size_sum[31:0];
  assign ovf_now  = ovf_q | size_sum[32];

  // Classify the item and build its byte burst descriptor
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    vlen_d  = vlen_q;
    size_d  = size_now;
    ovf_d   = ovf_now;
    amt_d   = '0;
    desc_o        = '0;
    desc_o.raw_en = 1'b1;
    desc_o.err    = 1'b1;
    if (accept) begin
      case (pblre_pkg::op_e'(op_i))
        pblre_pkg::OpStart: begin
          if (phase_q == PhIdle || phase_q == PhOpen) begin
            desc_o.raw_en     = 1'b0;
            desc_o.err        = 1'b0;
            desc_o.tag_pend   = 1'b1;
            desc_o.nsegs      = pblre_pkg::SegCntBits'(1);
            desc_o.seg[0].tag = pblre_pkg::TagTime;
            desc_o.seg[0].val = time_c;
            phase_d = PhOpen;
            left_d  = '0;
            vlen_d  = '0;
            size_d  = pblre_pkg::StartSize;
            ovf_d   = 1'b0;
          end
        end
        pblre_pkg::OpPair: begin
          if (phase_q == PhOpen) begin
            desc_o.raw_en     = 1'b0;
            desc_o.err        = 1'b0;
            desc_o.tag_pend   = 1'b1;
            desc_o.seg[0].tag = pblre_pkg::TagPair;
            desc_o.seg[0].val = 32'(content);
            desc_o.seg[1].tag = pblre_pkg::TagKey;
            desc_o.seg[1].val = 32'(kl);
            amt_d  = amount;
            vlen_d = vl;
            if (kl != '0) begin
              desc_o.nsegs = pblre_pkg::SegCntBits'(2);
              phase_d      = PhKey;
              left_d       = kl;
            end else begin
              // Empty key: the value header follows at once
              desc_o.nsegs      = pblre_pkg::SegCntBits'(3);
              desc_o.seg[2].tag = pblre_pkg::TagValue;
              desc_o.seg[2].val = 32'(vl);
              if (vl != '0) begin
                phase_d = PhValue;
                left_d  = vl;
              end else begin
                phase_d = PhOpen;
                left_d  = '0;
              end
            end
          end
        end
        pblre_pkg::OpData: begin
          if ((phase_q == PhKey || phase_q == PhValue) && left_q != '0) begin
            desc_o.err      = 1'b0;
            desc_o.raw_byte = data_byte_i;
            left_d          = left_dec;
            if (left_dec == '0) begin
              if (phase_q == PhKey) begin
                // Last key byte: append the value header
                desc_o.tag_pend   = 1'b1;
                desc_o.nsegs      = pblre_pkg::SegCntBits'(1);
                desc_o.seg[0].tag = pblre_pkg::TagValue;
                desc_o.seg[0].val = 32'(vlen_q);
                if (vlen_q != '0) begin
                  phase_d = PhValue;
                  left_d  = vlen_q;
                end else begin
                  phase_d = PhOpen;
                end
              end else begin
                phase_d = PhOpen;
              end
            end
          end
        end
        default: begin
          // Done: close the record and emit the header, or an error byte on overflow
          if (phase_q == PhOpen) begin
            phase_d = PhIdle;
            if (ovf_now) begin
              ovf_d = 1'b0;
            end else begin
              desc_o.raw_en     = 1'b0;
              desc_o.err        = 1'b0;
              desc_o.hdr        = 1'b1;
              desc_o.tag_pend   = 1'b1;
              desc_o.nsegs      = pblre_pkg::SegCntBits'(1);
              desc_o.seg[0].tag = pblre_pkg::TagHeader;
              desc_o.seg[0].val = size_now;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      left_q  <= '0;
      vlen_q  <= '0;
      size_q  <= '0;
      ovf_q   <= 1'b0;
      amt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      vlen_q  <= vlen_d;
      size_q  <= size_d;
      ovf_q   <= ovf_d;
      amt_q   <= amt_d;
    end
  end

endmodule

`default_nettype wire

### sv/pblre_fifo.sv
`default_nettype none

module pblre_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  pblre_pkg::desc_t      desc_i,
  input  wire logic             pop_i,
  output logic                  full_o,
  output logic                  empty_o,
  output pblre_pkg::desc_t      head_o
);

  pblre_pkg::desc_t                    mem_q [pblre_pkg::QueueDepth];
  logic [pblre_pkg::QPtrBits-1:0]      wr_ptr_q, wr_ptr_d;
  logic [pblre_pkg::QPtrBits-1:0]      rd_ptr_q, rd_ptr_d;
  logic [pblre_pkg::QPtrBits:0]        cnt_q, cnt_d;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store descriptors
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (pblre_pkg::QPtrBits + 1)'(pblre_pkg::QueueDepth));

endmodule

`default_nettype wire

### sv/pblre_back.sv
`default_nettype none

module pblre_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  pblre_pkg::desc_t      head_i,
  input  wire logic             empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  out_hdr_o,
  output logic                  out_err_o,
  output logic                  out_last_o
);

  logic             busy_q, busy_d;
  pblre_pkg::desc_t work_q, work_d;
  pblre_pkg::desc_t cur, nxt;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q;
  logic             out_hdr_q, out_err_q, out_last_q;
  logic [7:0]       byte_c;
  logic             done_c;
  logic             src_valid, can_emit, fire;

  // Work on the held remainder, or on a fresh queue head
  assign cur       = busy_q ? work_q : head_i;
  assign src_valid = busy_q || !empty_i;
  assign can_emit  = !out_valid_q || out_ready_i;
  assign fire      = src_valid && can_emit;
  assign pop_o     = fire && !busy_q;

  // Produce one byte of the burst and the remainder
  always_comb begin
    nxt    = cur;
    byte_c = '0;
    done_c = 1'b0;
    if (cur.raw_en) begin
      byte_c     = cur.raw_byte;
      nxt.raw_en = 1'b0;
      done_c     = (cur.nsegs == '0);
    end else if (cur.tag_pend) begin
      byte_c       = cur.seg[0].tag;
      nxt.tag_pend = 1'b0;
    end else if (cur.seg[0].val[31:7] != '0) begin
      byte_c         = {1'b1, cur.seg[0].val[6:0]};
      nxt.seg[0].val = {7'd0, cur.seg[0].val[31:7]};
    end else begin
      byte_c       = cur.seg[0].val[7:0];
      nxt.nsegs    = cur.nsegs - 1'b1;
      nxt.tag_pend = 1'b1;
      for (int i = 0; i < pblre_pkg::NumSegs - 1; i++) begin
        nxt.seg[i] = cur.seg[i+1];
      end
      nxt.seg[pblre_pkg::NumSegs-1] = '0;
      done_c = (cur.nsegs == pblre_pkg::SegCntBits'(1));
    end
  end

  // Hold or advance the remainder and the output register
  always_comb begin
    busy_d      = busy_q;
    work_d      = work_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      busy_d      = !done_c;
      work_d      = nxt;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (fire) begin
      out_byte_q <= byte_c;
      out_hdr_q  <= cur.hdr;
      out_err_q  <= cur.err;
      out_last_q <= done_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_hdr_o   = out_hdr_q;
  assign out_err_o   = out_err_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

### sv/protobuf_log_record_encoder_top.sv
// Log record encoder, protobuf wire form, one serialized byte per transfer.
// Input stream: tuser carries the op (start, pair header, data byte, done);
// tdata carries time, key length, value length and data byte. Each accepted
// item causes a burst of 1 to 10 output bytes; tlast marks the final byte of
// the burst, tuser flags header bytes (for placement at the record front)
// and error bytes (out-of-place item or record size overflow, data zero).
// A burst's first byte passes the descriptor queue and the output register
// before it is shown. The output side moves one byte per cycle while the
// receiver is ready; a data item that passes a key or value byte yields that
// byte (plus the value header after the last key byte), so bytes stream at
// full rate. The front classifies each item in its accept cycle and queues
// a burst descriptor (four entries); the back expands one descriptor a byte
// a cycle while the output is not stalled. Input ready drops only when the
// queue is full, so when the receiver stalls the output register holds its
// byte and up to four items more are taken. Reset clears the record state
// (no record open), queue and output register; no result is pending afterwards.
`default_nettype none

module protobuf_log_record_encoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] log_time, [47:32] key_length, [63:48] value_length, [71:64] data_byte
  input  wire logic [71:0] s_axis_tdata,
  // [1:0] op
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]       m_axis_tdata,
  // [0] is_header, [1] error
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  logic             push, pop, full, empty;
  pblre_pkg::desc_t push_desc, head_desc;
  logic             out_hdr, out_err;

  pblre_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .op_i           (s_axis_tuser),
    .log_time_i     (s_axis_tdata[31:0]),
    .key_length_i   (s_axis_tdata[47:32]),
    .value_length_i (s_axis_tdata[63:48]),
    .data_byte_i    (s_axis_tdata[71:64]),
    .full_i         (full),
    .push_o         (push),
    .desc_o         (push_desc)
  );

  pblre_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head_desc)
  );

  pblre_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_desc),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_hdr_o   (out_hdr),
    .out_err_o   (out_err),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = {out_err, out_hdr};

endmodule

`default_nettype wire

### sv/pblre_checker.sv
`default_nettype none

module pblre_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [71:0] s_axis_tdata,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // Stalled output transfer keeps its valid
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  // Stalled output transfer keeps its payload
  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // Error result is a lone zero byte, never a header byte
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      m_axis_tlast && (m_axis_tdata == 8'h00) && !m_axis_tuser[0])
    else $error("malformed error result");

  // Final header byte closes the size varint
  a_hdr_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] && m_axis_tlast |-> !m_axis_tdata[7])
    else $error("header ends with a continuation byte");

endmodule

bind protobuf_log_record_encoder_top pblre_checker u_checker (.*);

`default_nettype wire
